@@ sv/cpred_pkg.sv @@
// Shared constants and helper functions for the correlating branch predictor.
`default_nettype none
package cpred_pkg;

	// Width of one saturating pattern counter
	localparam int unsigned CTR_BITS = 2;

	// Pattern counter limits and the taken threshold
	localparam logic [CTR_BITS-1:0] CTR_MAX = 2'd3;
	localparam logic [CTR_BITS-1:0] CTR_MIN = 2'd0;
	localparam logic [CTR_BITS-1:0] CTR_TAKEN_MIN = 2'd2;

	// Statistics counters stop at all ones
	localparam logic [31:0] STAT_MAX = 32'hFFFF_FFFF;

	// Step a 2-bit counter up on taken, down on not taken, saturating
	function automatic logic [CTR_BITS-1:0] ctr_step(input logic [CTR_BITS-1:0] ctr,
		input logic up);
		logic [CTR_BITS-1:0] res;
		res = ctr;
		if (up) begin
			if (ctr != CTR_MAX) res = ctr + 2'd1;
		end else begin
			if (ctr != CTR_MIN) res = ctr - 2'd1;
		end
		return res;
	endfunction

	// Saturating increment of a statistics counter
	function automatic logic [31:0] stat_inc(input logic [31:0] v);
		return (v == STAT_MAX) ? v : v + 32'd1;
	endfunction

endpackage
`default_nettype wire

@@ sv/cpred_table.sv @@
// Pattern table memory: one read port, one write port, clearing sweep after reset.
`default_nettype none
module cpred_table #(
	parameter int unsigned INDEX_BITS = 10,
	parameter int unsigned ENTRY_BITS = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rd_en,
	input  wire logic [INDEX_BITS-1:0] rd_idx,
	output logic      [ENTRY_BITS-1:0] rd_data,
	input  wire logic                  wr_en,
	input  wire logic [INDEX_BITS-1:0] wr_idx,
	input  wire logic [ENTRY_BITS-1:0] wr_data,
	output logic                       busy
);

	localparam int unsigned DEPTH = 2 ** INDEX_BITS;

	logic [ENTRY_BITS-1:0] mem [DEPTH];
	logic [ENTRY_BITS-1:0] rd_data_q;
	logic [INDEX_BITS-1:0] clr_idx_q;
	logic                  busy_q;
	logic                  we;
	logic [INDEX_BITS-1:0] widx;
	logic [ENTRY_BITS-1:0] wdata;

	// Clearing sweep: one entry per cycle from index zero to the top
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_idx_q <= '0;
		end else if (busy_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (&clr_idx_q) busy_q <= 1'b0;
		end
	end

	// Write port select: sweep owns the port while busy
	always_comb begin
		we    = busy_q | wr_en;
		widx  = busy_q ? clr_idx_q : wr_idx;
		wdata = busy_q ? '0 : wr_data;
	end

	// Memory array, read data registered
	always_ff @(posedge clk) begin
		if (we) mem[widx] <= wdata;
		if (rd_en) rd_data_q <= mem[rd_idx];
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule
`default_nettype wire

@@ sv/cpred_update.sv @@
// Counter select, prediction and entry update for one table entry.
`default_nettype none
module cpred_update #(
	parameter int unsigned HISTORY_BITS = 4
) (
	input  wire logic [2*(2**HISTORY_BITS)-1:0] entry,
	input  wire logic [HISTORY_BITS-1:0]        hist,
	input  wire logic                           taken,
	output logic                                pred,
	output logic      [2*(2**HISTORY_BITS)-1:0] entry_next
);

	localparam int unsigned LANES = 2 ** HISTORY_BITS;

	logic [cpred_pkg::CTR_BITS-1:0] ctr;
	logic [cpred_pkg::CTR_BITS-1:0] ctr_next;

	// Pick the counter for this history pattern
	always_comb begin
		ctr      = entry[{hist, 1'b0} +: cpred_pkg::CTR_BITS];
		pred     = (ctr >= cpred_pkg::CTR_TAKEN_MIN);
		ctr_next = cpred_pkg::ctr_step(ctr, taken);
	end

	// Rebuild the entry with only the selected counter replaced
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			entry_next[cpred_pkg::CTR_BITS*i +: cpred_pkg::CTR_BITS] =
				(hist == HISTORY_BITS'(i)) ? ctr_next
				: entry[cpred_pkg::CTR_BITS*i +: cpred_pkg::CTR_BITS];
		end
	end

endmodule
`default_nettype wire

@@ sv/two_bit_correlating_predictor_hist4.sv @@
// Flow: a word's table read is registered into stage 1, and its result into the output register.
// Throughput: one word per cycle while the output side keeps taking results; the table
// is read once and written back once per word, a same-entry word right behind is forwarded.
// Reset: history and statistics clear at once; the pattern table is then swept to zero,
// all 2**INDEX_BITS entries (1024 by default), and no word is accepted during the sweep.
`default_nettype none
module two_bit_correlating_predictor_hist4 #(
	parameter int unsigned INDEX_BITS   = 10,
	parameter int unsigned HISTORY_BITS = 4,
	parameter int unsigned PC_SHIFT     = 3
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] branch_pc,
	input  wire logic        was_taken,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             predicted_taken,
	output logic             mispredicted,
	output logic      [31:0] branch_total,
	output logic      [31:0] mispredict_total
);

	localparam int unsigned ENTRY_BITS = cpred_pkg::CTR_BITS * (2 ** HISTORY_BITS);

	logic                    tbl_busy;
	logic [ENTRY_BITS-1:0]   rd_data;
	logic [ENTRY_BITS-1:0]   entry_cur;
	logic [ENTRY_BITS-1:0]   entry_next;
	logic                    pred;
	logic                    accept;
	logic                    go_s1;

	logic                    valid_s1;
	logic [INDEX_BITS-1:0]   idx_s1;
	logic                    taken_s1;

	logic                    fwd_valid_q;
	logic [INDEX_BITS-1:0]   fwd_idx_q;
	logic [ENTRY_BITS-1:0]   fwd_data_q;

	logic [HISTORY_BITS-1:0] hist_q;
	logic [31:0]             br_cnt_q;
	logic [31:0]             miss_cnt_q;
	logic [31:0]             br_cnt_next;
	logic [31:0]             miss_cnt_next;
	logic                    miss;

	logic                    out_valid_q;
	logic                    pred_q;
	logic                    miss_q;

	// Handshake: stage 1 drains into the output register when it is free
	assign go_s1    = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~tbl_busy & (~valid_s1 | go_s1);
	assign accept   = in_valid & in_ready;

	cpred_table #(
		.INDEX_BITS (INDEX_BITS),
		.ENTRY_BITS (ENTRY_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (branch_pc[PC_SHIFT +: INDEX_BITS]),
		.rd_data (rd_data),
		.wr_en   (go_s1),
		.wr_idx  (idx_s1),
		.wr_data (entry_next),
		.busy    (tbl_busy)
	);

	// Forward the last written entry over a read that saw stale data
	assign entry_cur = (fwd_valid_q && fwd_idx_q == idx_s1) ? fwd_data_q : rd_data;

	cpred_update #(
		.HISTORY_BITS (HISTORY_BITS)
	) u_update (
		.entry      (entry_cur),
		.hist       (hist_q),
		.taken      (taken_s1),
		.pred       (pred),
		.entry_next (entry_next)
	);

	// Statistics next values
	always_comb begin
		miss          = pred ^ taken_s1;
		br_cnt_next   = cpred_pkg::stat_inc(br_cnt_q);
		miss_cnt_next = miss ? cpred_pkg::stat_inc(miss_cnt_q) : miss_cnt_q;
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1   <= branch_pc[PC_SHIFT +: INDEX_BITS];
			taken_s1 <= was_taken;
		end
	end

	// Forwarding register, history and statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
			hist_q      <= '0;
			br_cnt_q    <= '0;
			miss_cnt_q  <= '0;
		end else if (go_s1) begin
			fwd_valid_q <= 1'b1;
			hist_q      <= HISTORY_BITS'({hist_q, taken_s1});
			br_cnt_q    <= br_cnt_next;
			miss_cnt_q  <= miss_cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= entry_next;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			pred_q <= pred;
			miss_q <= miss;
		end
	end

	assign out_valid        = out_valid_q;
	assign predicted_taken  = pred_q;
	assign mispredicted     = miss_q;
	assign branch_total     = br_cnt_q;
	assign mispredict_total = miss_cnt_q;

	// No word sits in stage 1 while the table is being cleared
	a_no_work_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_busy |-> !valid_s1)
		else $error("word in stage 1 during table clear");

	// A new result only appears after a word left stage 1
	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s1))
		else $error("result without a word in stage 1");

	// Mispredictions never outnumber branches
	a_miss_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		mispredict_total <= branch_total)
		else $error("mispredict count exceeds branch count");

	// Each result advances the branch count by one until it saturates
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && branch_total != cpred_pkg::STAT_MAX |=>
			branch_total == $past(branch_total) + 32'd1)
		else $error("branch count did not advance");

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for the (4,2) correlating branch predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned INDEX_BITS   = 10;
	localparam int unsigned HISTORY_BITS = 4;
	localparam int unsigned PC_SHIFT     = 3;
	localparam int unsigned TABLE_DEPTH  = 1 << INDEX_BITS;
	localparam int unsigned HIST_DEPTH   = 1 << HISTORY_BITS;
	// quiet cycles allowed: covers the table sweep after reset plus worst stalls
	localparam int unsigned QUIET_LIMIT  = 6000;
	localparam int unsigned MAX_REPORTS  = 10;

	typedef struct {
		logic [31:0] pc;
		logic        taken;
		bit          drain;
		int unsigned idle_pct;
	} branch_word_t;

	typedef struct {
		logic        predicted_taken;
		logic        mispredicted;
		logic [31:0] branch_total;
		logic [31:0] mispredict_total;
	} branch_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [31:0] branch_pc = '0;
	logic        was_taken = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        predicted_taken;
	logic        mispredicted;
	logic [31:0] branch_total;
	logic [31:0] mispredict_total;

	// predictor state mirrored in the testbench
	logic [cpred_pkg::CTR_BITS-1:0] pattern_rows [TABLE_DEPTH][HIST_DEPTH];
	logic [HISTORY_BITS-1:0] global_hist = '0;
	logic [31:0]             branches_seen = '0;
	logic [31:0]             misses_seen = '0;

	branch_word_t   branch_q [$];
	branch_result_t outcome_q [$];

	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned cur_idle_pct = 0;
	int unsigned error_count = 0;
	int unsigned quiet_cycles = 0;

	two_bit_correlating_predictor_hist4 #(
		.INDEX_BITS  (INDEX_BITS),
		.HISTORY_BITS(HISTORY_BITS),
		.PC_SHIFT    (PC_SHIFT)
	) i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.branch_pc       (branch_pc),
		.was_taken       (was_taken),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.predicted_taken (predicted_taken),
		.mispredicted    (mispredicted),
		.branch_total    (branch_total),
		.mispredict_total(mispredict_total)
	);

	// Predict one branch and update the mirrored table, history and stats
	function automatic branch_result_t resolve_branch(input logic [31:0] pc, input logic taken);
		branch_result_t      r;
		logic [INDEX_BITS-1:0] row;
		logic [cpred_pkg::CTR_BITS-1:0] ctr;
		row = pc[PC_SHIFT +: INDEX_BITS];
		ctr = pattern_rows[row][global_hist];
		r.predicted_taken = (ctr >= cpred_pkg::CTR_TAKEN_MIN);
		r.mispredicted = (r.predicted_taken != taken);
		if (taken) begin
			if (ctr != cpred_pkg::CTR_MAX) ctr = ctr + 1'b1;
		end else begin
			if (ctr != cpred_pkg::CTR_MIN) ctr = ctr - 1'b1;
		end
		pattern_rows[row][global_hist] = ctr;
		global_hist = {global_hist[HISTORY_BITS-2:0], taken};
		if (branches_seen != cpred_pkg::STAT_MAX)
			branches_seen = branches_seen + 32'd1;
		if (r.mispredicted && misses_seen != cpred_pkg::STAT_MAX)
			misses_seen = misses_seen + 32'd1;
		r.branch_total = branches_seen;
		r.mispredict_total = misses_seen;
		return r;
	endfunction

	task automatic add_word(input logic [31:0] pc, input logic taken, input bit drain,
		input int unsigned idle_pct);
		branch_word_t w;
		w.pc = pc;
		w.taken = taken;
		w.drain = drain;
		w.idle_pct = idle_pct;
		branch_q.push_back(w);
	endtask

	// Clock
	initial begin
		forever #1 clk = ~clk;
	end

	// Driver: predicts on acceptance, then presents the next pending word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			branch_word_t w;
			if (in_valid && in_ready)
				outcome_q.push_back(resolve_branch(branch_pc, was_taken));
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (branch_q.size() != 0 &&
					!(branch_q[0].drain && outcome_q.size() != 0)) begin
					w = branch_q.pop_front();
					in_valid <= 1'b1;
					branch_pc <= w.pc;
					was_taken <= w.taken;
					cur_idle_pct <= w.idle_pct;
					// idle burst after this word is taken
					if ($urandom_range(0, 99) < w.idle_pct)
						gap_left <= $urandom_range(1, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			branch_result_t e;
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					error_count <= error_count + 1;
					if (error_count < MAX_REPORTS)
						$display("ERROR: extra result p=%0d m=%0d t=%0d mt=%0d",
							predicted_taken, mispredicted, branch_total, mispredict_total);
				end else begin
					e = outcome_q.pop_front();
					if (predicted_taken !== e.predicted_taken ||
						mispredicted !== e.mispredicted ||
						branch_total !== e.branch_total ||
						mispredict_total !== e.mispredict_total) begin
						error_count <= error_count + 1;
						if (error_count < MAX_REPORTS)
							$display("ERROR: exp p=%0d m=%0d t=%0d mt=%0d got p=%0d m=%0d t=%0d mt=%0d",
								e.predicted_taken, e.mispredicted, e.branch_total,
								e.mispredict_total, predicted_taken, mispredicted,
								branch_total, mispredict_total);
					end
				end
			end
			// output stalls in bursts of random length, started at the idle rate of the last word sent
			if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < cur_idle_pct) begin
				stall_left <= $urandom_range(0, 4);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog on cycles with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("two_bit_correlating_predictor_hist4 test failed");
			$finish;
		end
	end

	// Stimulus and end of run
	initial begin
		logic [31:0] hot_pc [8];
		int unsigned hot_bias [8];
		int unsigned pct;
		int unsigned stop_at;
		int unsigned sel;
		int unsigned h;
		int unsigned n;

		foreach (pattern_rows[i, j]) pattern_rows[i][j] = '0;

		// directed: saturate one counter up with all-taken history, then not-taken words step counters down
		repeat (8) add_word(32'h0000_0000, 1'b1, 1'b0, 0);
		repeat (6) add_word(32'h0000_0000, 1'b0, 1'b0, 0);
		// all-ones address, both outcomes
		add_word(32'hFFFF_FFFF, 1'b1, 1'b0, 0);
		add_word(32'hFFFF_FFFF, 1'b0, 1'b0, 0);
		// aliasing through high address bits and ignored low bits
		add_word(32'h0000_1238, 1'b1, 1'b0, 0);
		add_word(32'hABCD_F238, 1'b1, 1'b0, 0);
		add_word(32'h0000_123F, 1'b0, 1'b0, 0);
		add_word(32'hFFFF_F238, 1'b1, 1'b0, 0);
		add_word(32'h8000_0007, 1'b1, 1'b0, 0);
		add_word(32'h7FFF_FFF8, 1'b0, 1'b0, 0);

		// hot branch pool, two of them aliasing with the first
		for (int i = 0; i < 8; i++) begin
			hot_pc[i] = $urandom;
			case ($urandom_range(0, 3))
				0: hot_bias[i] = 95;
				1: hot_bias[i] = 5;
				2: hot_bias[i] = 50;
				default: hot_bias[i] = 80;
			endcase
		end
		hot_pc[6] = {hot_pc[0][31:13] ^ 19'h5A5A5, hot_pc[0][12:0]};
		hot_pc[7] = {hot_pc[0][31:3], ~hot_pc[0][2:0]};

		// random part in chunks, each with its own idle rate; the last ones calm
		for (int c = 0; c < 15; c++) begin
			if (c >= 13) begin
				pct = 0;
			end else begin
				case ($urandom_range(0, 2))
					0: pct = 0;
					1: pct = 15;
					default: pct = 50;
				endcase
			end
			stop_at = branch_q.size() + 50;
			// sender waits for all results before the first random word and mid-run
			if (c == 0 || c == 7)
				add_word($urandom, 1'($urandom_range(0, 1)), 1'b1, pct);
			while (branch_q.size() < stop_at) begin
				sel = $urandom_range(0, 99);
				h = $urandom_range(0, 7);
				if (sel < 60) begin
					add_word(hot_pc[h], ($urandom_range(0, 99) < hot_bias[h]), 1'b0, pct);
				end else if (sel < 80) begin
					// loop-like burst: taken several times then falls through
					n = $urandom_range(2, 6);
					repeat (n) add_word(hot_pc[h], 1'b1, 1'b0, pct);
					add_word(hot_pc[h], 1'b0, 1'b0, pct);
				end else begin
					add_word($urandom, 1'($urandom_range(0, 1)), 1'b0, pct);
				end
			end
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (branch_q.size() != 0 || in_valid || outcome_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (error_count == 0 && outcome_q.size() == 0)
			$display("two_bit_correlating_predictor_hist4 test passed");
		else
			$display("two_bit_correlating_predictor_hist4 test failed");
		$finish;
	end

endmodule
